### sv/upc_pkg.sv
// Package for the URL percent codec: shared types, codes and character helpers.
// Used by every module of the codec; depends on nothing else.
package upc_pkg;

	// Depth of the command queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Character codes used by the codec.
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// Escape tracking in the decoder.
	typedef enum logic [1:0] {
		ESC_IDLE  = 2'd0,
		ESC_PCT   = 2'd1,
		ESC_DIGIT = 2'd2
	} esc_t;

	// Back end sequencing: fetch a command, then the two hex digits of an escape.
	typedef enum logic [1:0] {
		BK_FETCH = 2'd0,
		BK_HI    = 2'd1,
		BK_LO    = 2'd2
	} bk_state_t;

	// One queued command: either a byte to emit as is, or a byte to expand
	// into a percent triple.
	typedef struct packed {
		logic       expand;
		logic [7:0] data;
	} cmd_t;

	// True for the 27 reserved or unsafe characters.
	function automatic logic is_listed(input logic [7:0] c);
		logic hit;
		hit = c inside {8'h24, 8'h26, 8'h2b, 8'h2c, 8'h2f, 8'h3a, 8'h3b, 8'h3d, 8'h3f,
				8'h40, 8'h20, 8'h22, 8'h3c, 8'h3e, 8'h23, 8'h25, 8'h7b, 8'h7d,
				8'h7c, 8'h5c, 8'h5e, 8'h7e, 8'h5b, 8'h5d, 8'h60, 8'h28, 8'h29};
		return hit;
	endfunction

	// Lowercase hex character of a nibble.
	function automatic logic [7:0] lower_hex(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'd0, nib};
		end else begin
			r = 8'h57 + {4'd0, nib};
		end
		return r;
	endfunction

	// Value of an uppercase hex digit; bit 4 set means not a digit.
	function automatic logic [4:0] upper_hex_value(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, c[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, c[3:0] + 4'd9};
		end else begin
			r = 5'h10;
		end
		return r;
	endfunction

endpackage

### sv/upc_front.sv
// Front end of the URL percent codec: accepts input items, tracks escapes and
// classifies each item into a queue command. Depends on upc_pkg.
module upc_front import upc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       direction,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       string_end,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	esc_t       esc_q, esc_d;
	logic [7:0] held_q, held_d;
	logic       accept;
	logic       emit;
	logic [4:0] hi_val, lo_val;
	logic [7:0] dec_val;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && emit;

	// Digit values of a completed triple.
	assign hi_val  = upper_hex_value(held_q);
	assign lo_val  = upper_hex_value(in_byte);
	assign dec_val = {hi_val[3:0], lo_val[3:0]};

	// Next escape state and held digit.
	always_comb begin
		esc_d  = esc_q;
		held_d = held_q;
		if (accept) begin
			if (!direction) begin
				esc_d  = ESC_IDLE;
				held_d = 8'd0;
			end else begin
				case (esc_q)
					ESC_PCT: begin
						esc_d  = ESC_DIGIT;
						held_d = in_byte;
					end
					ESC_DIGIT: begin
						esc_d  = ESC_IDLE;
						held_d = 8'd0;
					end
					default: begin
						esc_d = (in_byte == CH_PERCENT) ? ESC_PCT : ESC_IDLE;
					end
				endcase
				if (string_end) begin
					esc_d  = ESC_IDLE;
					held_d = 8'd0;
				end
			end
		end
	end

	// Command classification for the accepted item.
	always_comb begin
		emit   = 1'b0;
		q_cmd  = '{expand: 1'b0, data: in_byte};
		if (!direction) begin
			emit         = 1'b1;
			q_cmd.expand = is_listed(in_byte);
		end else begin
			case (esc_q)
				ESC_PCT: begin
					emit = 1'b0;
				end
				ESC_DIGIT: begin
					emit       = !hi_val[4] && !lo_val[4] && is_listed(dec_val);
					q_cmd.data = dec_val;
				end
				default: begin
					emit = (in_byte != CH_PERCENT);
					if (in_byte == CH_PLUS) begin
						q_cmd.data = CH_SPACE;
					end
				end
			endcase
		end
	end

	// Escape state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= ESC_IDLE;
			held_q <= 8'd0;
		end else begin
			esc_q  <= esc_d;
			held_q <= held_d;
		end
	end

endmodule

### sv/upc_queue.sv
// Short command queue between front and back of the URL percent codec.
// Register-based FIFO of QDEPTH entries; depends on upc_pkg.
module upc_queue import upc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output cmd_t head_cmd
);

	cmd_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     count_q;

	assign full     = (count_q == (QAW+1)'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign head_cmd = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/upc_back.sv
// Back end of the URL percent codec: turns queue commands into output items,
// expanding escapes into three bytes, with a registered output. Depends on upc_pkg.
module upc_back import upc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nonempty,
	input  cmd_t       q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);

	bk_state_t  st_q, st_d;
	logic [7:0] byte_q;
	logic       valid_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       slot;
	logic       load;
	logic [7:0] load_byte;
	logic       load_last;

	assign slot      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_byte  = data_q;
	assign run_last  = last_q;

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_FETCH: begin
				if (slot && q_nonempty && q_head.expand) begin
					st_d = BK_HI;
				end
			end
			BK_HI: begin
				if (slot) begin
					st_d = BK_LO;
				end
			end
			BK_LO: begin
				if (slot) begin
					st_d = BK_FETCH;
				end
			end
			default: begin
				st_d = BK_FETCH;
			end
		endcase
	end

	// Outputs of the sequencer: what to load into the output register.
	always_comb begin
		q_pop     = 1'b0;
		load      = 1'b0;
		load_byte = byte_q;
		load_last = 1'b0;
		case (st_q)
			BK_FETCH: begin
				q_pop     = slot && q_nonempty;
				load      = slot && q_nonempty;
				load_byte = q_head.expand ? CH_PERCENT : q_head.data;
				load_last = !q_head.expand;
			end
			BK_HI: begin
				load      = slot;
				load_byte = lower_hex(byte_q[7:4]);
			end
			BK_LO: begin
				load      = slot;
				load_byte = lower_hex(byte_q[3:0]);
				load_last = 1'b1;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// Byte being expanded and output payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q <= q_head.data;
		end
		if (load) begin
			data_q <= load_byte;
			last_q <= load_last;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= BK_FETCH;
			valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

### sv/url_percent_codec.sv
// Top level of the URL percent codec: direction register, front, queue and back.
// Depends on upc_pkg, upc_front, upc_queue and upc_back.
//
// The codec takes one byte per cycle on the input stream while the queue is
// not full and, with direction 0, percent-encodes the 27 reserved characters
// as '%' plus two lowercase hex digits; with direction 1 it decodes '+' to
// space and uppercase percent triples of listed characters, drops other
// triples and passes other bytes through. An input byte that passes through
// or completes a decoded triple gives one output item, held in the command
// queue and then in the output register. An encoded byte gives three items,
// one per cycle while the output is ready. A stream of reserved characters is
// therefore limited by the back end, which emits at most one output byte per
// cycle. A four-entry command queue lets input be taken while earlier items
// are still being emitted. tlast on the output marks the last byte produced
// by one queued command. Change direction only while the codec is idle.
module url_percent_codec import upc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // string_end
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast    // run_last
);

	logic direction_q;
	logic q_push, q_pop, q_full, q_nonempty;
	cmd_t push_cmd, head_cmd;

	// Configuration register: direction at byte address 0.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, direction_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			direction_q <= pwdata[0];
		end
	end

	// Front end: accept and classify.
	upc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.direction  (direction_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.string_end (s_tlast),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (push_cmd)
	);

	// Command queue.
	upc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head_cmd (head_cmd)
	);

	// Back end: emit output items.
	upc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (head_cmd),
		.q_pop      (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.run_last   (m_tlast)
	);

endmodule
